// File: hw/rtl/bmhq_pkg.sv
// binary min-heap queue: shared types, codes and defaults
// used by bmhq_ctrl, bmhq_datapath and binary_min_heap_queue
package bmhq_pkg;

  localparam int unsigned DefCapacity     = 64;
  localparam int unsigned DefKeyWidth     = 16;
  localparam int unsigned DefPayloadWidth = 16;

  localparam int unsigned LimitW = 7;
  localparam logic [LimitW-1:0] LimitReset = 7'd64;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_UP_RD,
    S_UP_CMP,
    S_POP_RD,
    S_POP_LD,
    S_DN_RD,
    S_DN_CMP,
    S_DONE
  } state_e;

  typedef struct packed {
    logic accept;
    logic decode;
    logic up_rd;
    logic up_move;
    logic pop_rd;
    logic pop_ld;
    logic dn_rd;
    logic dn_move;
    logic place;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic is_pop;
    logic push_ok;
    logic pop_ok;
    logic at_root;
    logic up_go;
    logic leaf;
    logic dn_go;
    logic res_free;
  } stat_t;

endpackage

// File: hw/rtl/bmhq_ctrl.sv
// binary min-heap queue: sequencing state machine for push and pop
// depends on bmhq_pkg
module bmhq_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  bmhq_pkg::stat_t stat_i,
  output bmhq_pkg::cmd_t  cmd_o
);

  bmhq_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bmhq_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      bmhq_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = bmhq_pkg::S_DECODE;
        end
      end
      bmhq_pkg::S_DECODE: begin
        cmd_o.decode = 1'b1;
        if (stat_i.is_pop) begin
          state_d = stat_i.pop_ok ? bmhq_pkg::S_POP_RD : bmhq_pkg::S_DONE;
        end else begin
          state_d = stat_i.push_ok ? bmhq_pkg::S_UP_RD : bmhq_pkg::S_DONE;
        end
      end
      bmhq_pkg::S_UP_RD: begin
        if (stat_i.at_root) begin
          cmd_o.place = 1'b1;
          state_d     = bmhq_pkg::S_DONE;
        end else begin
          cmd_o.up_rd = 1'b1;
          state_d     = bmhq_pkg::S_UP_CMP;
        end
      end
      bmhq_pkg::S_UP_CMP: begin
        if (stat_i.up_go) begin
          cmd_o.up_move = 1'b1;
          state_d       = bmhq_pkg::S_UP_RD;
        end else begin
          cmd_o.place = 1'b1;
          state_d     = bmhq_pkg::S_DONE;
        end
      end
      bmhq_pkg::S_POP_RD: begin
        cmd_o.pop_rd = 1'b1;
        state_d      = bmhq_pkg::S_POP_LD;
      end
      bmhq_pkg::S_POP_LD: begin
        cmd_o.pop_ld = 1'b1;
        state_d      = bmhq_pkg::S_DN_RD;
      end
      bmhq_pkg::S_DN_RD: begin
        if (stat_i.leaf) begin
          cmd_o.place = 1'b1;
          state_d     = bmhq_pkg::S_DONE;
        end else begin
          cmd_o.dn_rd = 1'b1;
          state_d     = bmhq_pkg::S_DN_CMP;
        end
      end
      bmhq_pkg::S_DN_CMP: begin
        if (stat_i.dn_go) begin
          cmd_o.dn_move = 1'b1;
          state_d       = bmhq_pkg::S_DN_RD;
        end else begin
          cmd_o.place = 1'b1;
          state_d     = bmhq_pkg::S_DONE;
        end
      end
      bmhq_pkg::S_DONE: begin
        if (stat_i.res_free) begin
          cmd_o.finish = 1'b1;
          state_d      = bmhq_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = bmhq_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// File: hw/rtl/bmhq_datapath.sv
// binary min-heap queue: entry memory, hole pointer, count, limit and result registers
// depends on bmhq_pkg
module bmhq_datapath #(
  parameter int unsigned CAPACITY      = bmhq_pkg::DefCapacity,
  parameter int unsigned KEY_WIDTH     = bmhq_pkg::DefKeyWidth,
  parameter int unsigned PAYLOAD_WIDTH = bmhq_pkg::DefPayloadWidth,
  localparam int unsigned AddrW        = $clog2(CAPACITY),
  localparam int unsigned CntW         = $clog2(CAPACITY + 1)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  bmhq_pkg::cmd_t               cmd_i,
  output bmhq_pkg::stat_t              stat_o,
  input  logic                         action_i,
  input  logic [KEY_WIDTH-1:0]         key_i,
  input  logic [PAYLOAD_WIDTH-1:0]     payload_i,
  input  logic                         cfg_we_i,
  input  logic [bmhq_pkg::LimitW-1:0]  cfg_wdata_i,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  output logic [1:0]                   status_o,
  output logic [KEY_WIDTH-1:0]         popped_key_o,
  output logic [PAYLOAD_WIDTH-1:0]     popped_payload_o,
  output logic [KEY_WIDTH-1:0]         top_key_o,
  output logic [PAYLOAD_WIDTH-1:0]     top_payload_o,
  output logic [CntW-1:0]              entry_count_o,
  output logic                         is_empty_o
);

  localparam int unsigned EntW = KEY_WIDTH + PAYLOAD_WIDTH;
  localparam int unsigned ExtW = AddrW + 2;
  localparam int unsigned CmpW = (CntW > bmhq_pkg::LimitW) ? CntW : bmhq_pkg::LimitW;

  logic [EntW-1:0] mem_q [CAPACITY];

  logic                        op_q;
  logic [EntW-1:0]             ent_q;
  logic [AddrW-1:0]            pos_q;
  logic [CntW-1:0]             cnt_q;
  logic [bmhq_pkg::LimitW-1:0] limit_q;
  logic [EntW-1:0]             rd_a_q, rd_b_q;
  logic [EntW-1:0]             top_q;
  bmhq_pkg::status_e           rstat_q;
  logic [KEY_WIDTH-1:0]        pk_q;
  logic [PAYLOAD_WIDTH-1:0]    pp_q;
  logic                        out_valid_q;
  bmhq_pkg::status_e           res_status_q;
  logic [KEY_WIDTH-1:0]        res_pk_q, res_tk_q;
  logic [PAYLOAD_WIDTH-1:0]    res_pp_q, res_tp_q;
  logic [CntW-1:0]             res_cnt_q;
  logic                        res_empty_q;

  logic [ExtW-1:0]      left_w, right_w, cnt_ext;
  logic [AddrW-1:0]     parent_w, best_idx, raddr_a, raddr_b, waddr;
  logic                 right_ok, pick_b, push_ok, pop_ok, we;
  logic [KEY_WIDTH-1:0] e_key, ra_key, rb_key, best_key;
  logic [EntW-1:0]      best_ent, wdata;

  assign left_w   = {1'b0, pos_q, 1'b1};
  assign right_w  = left_w + ExtW'(1);
  assign cnt_ext  = ExtW'(cnt_q);
  assign right_ok = right_w < cnt_ext;
  assign parent_w = AddrW'((pos_q - AddrW'(1)) >> 1);

  assign e_key    = ent_q[EntW-1 -: KEY_WIDTH];
  assign ra_key   = rd_a_q[EntW-1 -: KEY_WIDTH];
  assign rb_key   = rd_b_q[EntW-1 -: KEY_WIDTH];
  assign pick_b   = right_ok && (rb_key < ra_key);
  assign best_ent = pick_b ? rd_b_q : rd_a_q;
  assign best_key = best_ent[EntW-1 -: KEY_WIDTH];
  assign best_idx = pick_b ? right_w[AddrW-1:0] : left_w[AddrW-1:0];

  assign push_ok = (CmpW'(cnt_q) < CmpW'(limit_q)) && (cnt_q < CntW'(CAPACITY));
  assign pop_ok  = cnt_q != '0;

  assign stat_o.is_pop   = op_q;
  assign stat_o.push_ok  = push_ok;
  assign stat_o.pop_ok   = pop_ok;
  assign stat_o.at_root  = pos_q == '0;
  assign stat_o.up_go    = e_key < ra_key;
  assign stat_o.leaf     = left_w >= cnt_ext;
  assign stat_o.dn_go    = best_key < e_key;
  assign stat_o.res_free = !out_valid_q || out_ready_i;

  always_comb begin
    raddr_a = '0;
    raddr_b = '0;
    if (cmd_i.up_rd) begin
      raddr_a = parent_w;
    end
    if (cmd_i.dn_rd) begin
      raddr_a = left_w[AddrW-1:0];
      raddr_b = right_w[AddrW-1:0];
    end
    if (cmd_i.pop_rd) begin
      raddr_b = AddrW'(cnt_q - CntW'(1));
    end
  end

  assign we    = cmd_i.up_move || cmd_i.dn_move || cmd_i.place;
  assign waddr = pos_q;
  assign wdata = cmd_i.place ? ent_q : (cmd_i.up_move ? rd_a_q : best_ent);

  // entry memory, one write and two registered reads
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rd_a_q <= mem_q[raddr_a];
    rd_b_q <= mem_q[raddr_b];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      limit_q     <= bmhq_pkg::LimitReset;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (cmd_i.decode && !op_q && push_ok) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (cmd_i.pop_ld) begin
        cnt_q <= cnt_q - CntW'(1);
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q  <= action_i;
      ent_q <= {key_i, payload_i};
    end
    if (cmd_i.decode) begin
      pk_q  <= '0;
      pp_q  <= '0;
      pos_q <= AddrW'(cnt_q);
      if (op_q) begin
        rstat_q <= pop_ok ? bmhq_pkg::ST_DONE : bmhq_pkg::ST_EMPTY;
      end else begin
        rstat_q <= push_ok ? bmhq_pkg::ST_DONE : bmhq_pkg::ST_FULL;
      end
    end
    if (cmd_i.up_move) begin
      pos_q <= parent_w;
    end
    if (cmd_i.pop_ld) begin
      pk_q  <= rd_a_q[EntW-1 -: KEY_WIDTH];
      pp_q  <= rd_a_q[PAYLOAD_WIDTH-1:0];
      ent_q <= rd_b_q;
      pos_q <= '0;
    end
    if (cmd_i.dn_move) begin
      pos_q <= best_idx;
    end
    // root copy follows every write to slot zero
    if (we && waddr == '0) begin
      top_q <= wdata;
    end
    if (cmd_i.finish) begin
      res_status_q <= rstat_q;
      res_pk_q     <= pk_q;
      res_pp_q     <= pp_q;
      res_tk_q     <= pop_ok ? top_q[EntW-1 -: KEY_WIDTH] : '0;
      res_tp_q     <= pop_ok ? top_q[PAYLOAD_WIDTH-1:0] : '0;
      res_cnt_q    <= cnt_q;
      res_empty_q  <= !pop_ok;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = res_status_q;
  assign popped_key_o     = res_pk_q;
  assign popped_payload_o = res_pp_q;
  assign top_key_o        = res_tk_q;
  assign top_payload_o    = res_tp_q;
  assign entry_count_o    = res_cnt_q;
  assign is_empty_o       = res_empty_q;

endmodule

// File: hw/rtl/binary_min_heap_queue.sv
// binary min-heap priority queue, top level
// depends on bmhq_pkg, bmhq_ctrl and bmhq_datapath
//
// Input channel (in_valid_i/in_ready_o) takes one word: action_i (0 push, 1 pop),
// key_i and payload_i. Output channel (out_valid_o/out_ready_i) returns one word
// per input word: status, popped entry, new top entry, entry count and empty flag.
// cfg_we_i writes the capacity limit from cfg_wdata_i; it is taken at once.
// One word is worked on at a time, in a single-ported-write entry memory with
// two registered read ports. Each heap level is a read, then a compare and
// move. A push climbs from the new slot until it stops or reaches the root; a
// pop reads the root and the last entry, puts the last entry in the root's
// place and walks it down until it stops or reaches a leaf. Rejected pushes and
// pops on an empty heap go from decode straight to the result, and the block
// returns to idle before it accepts the next word.
// The result sits in an output register: the next word is accepted while it
// waits, and that word's result is held back until the receiver takes it.
// Reset empties the heap and sets the limit to 64; memory is not cleared.
module binary_min_heap_queue #(
  parameter int unsigned CAPACITY      = bmhq_pkg::DefCapacity,
  parameter int unsigned KEY_WIDTH     = bmhq_pkg::DefKeyWidth,
  parameter int unsigned PAYLOAD_WIDTH = bmhq_pkg::DefPayloadWidth,
  localparam int unsigned CntW         = $clog2(CAPACITY + 1)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         action_i,
  input  logic [KEY_WIDTH-1:0]         key_i,
  input  logic [PAYLOAD_WIDTH-1:0]     payload_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [1:0]                   status_o,
  output logic [KEY_WIDTH-1:0]         popped_key_o,
  output logic [PAYLOAD_WIDTH-1:0]     popped_payload_o,
  output logic [KEY_WIDTH-1:0]         top_key_o,
  output logic [PAYLOAD_WIDTH-1:0]     top_payload_o,
  output logic [CntW-1:0]              entry_count_o,
  output logic                         is_empty_o,
  input  logic                         cfg_we_i,
  input  logic [bmhq_pkg::LimitW-1:0]  cfg_wdata_i
);

  bmhq_pkg::cmd_t  cmd;
  bmhq_pkg::stat_t stat;

  bmhq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  bmhq_datapath #(
    .CAPACITY      (CAPACITY),
    .KEY_WIDTH     (KEY_WIDTH),
    .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .action_i         (action_i),
    .key_i            (key_i),
    .payload_i        (payload_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .out_ready_i      (out_ready_i),
    .out_valid_o      (out_valid_o),
    .status_o         (status_o),
    .popped_key_o     (popped_key_o),
    .popped_payload_o (popped_payload_o),
    .top_key_o        (top_key_o),
    .top_payload_o    (top_payload_o),
    .entry_count_o    (entry_count_o),
    .is_empty_o       (is_empty_o)
  );

endmodule

// File: tb/binary_min_heap_queue_checker.sv
// binary min-heap queue checker: follows both channels and the limit register,
// keeps its own heap to predict each result word and compares it field by field
// depends on bmhq_pkg
module binary_min_heap_queue_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_ready_i,
  input  logic                      action_i,
  input  logic [15:0]               key_i,
  input  logic [15:0]               payload_i,
  input  logic                      out_valid_i,
  input  logic                      out_ready_i,
  input  logic [1:0]                status_i,
  input  logic [15:0]               popped_key_i,
  input  logic [15:0]               popped_payload_i,
  input  logic [15:0]               top_key_i,
  input  logic [15:0]               top_payload_i,
  input  logic [6:0]                entry_count_i,
  input  logic                      is_empty_i,
  input  logic                      cfg_we_i,
  input  logic [bmhq_pkg::LimitW-1:0] cfg_wdata_i,
  output int unsigned               mismatch_o,
  output int unsigned               pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Cap  = bmhq_pkg::DefCapacity;
  localparam int unsigned KeyW = bmhq_pkg::DefKeyWidth;
  localparam int unsigned PayW = bmhq_pkg::DefPayloadWidth;
  localparam int unsigned CntW = $clog2(bmhq_pkg::DefCapacity + 1);

  typedef struct packed {
    bmhq_pkg::status_e status;
    logic [KeyW-1:0]   popped_key;
    logic [PayW-1:0]   popped_tag;
    logic [KeyW-1:0]   top_key;
    logic [PayW-1:0]   top_tag;
    logic [CntW-1:0]   count;
    logic              empty;
  } heap_result_t;

  logic [KeyW-1:0]             heap_key [Cap];
  logic [PayW-1:0]             heap_tag [Cap];
  int unsigned                 held;
  logic [bmhq_pkg::LimitW-1:0] cap_limit;
  heap_result_t                result_q [$];
  heap_result_t                exp_r;
  heap_result_t                got_r;

  task automatic swap_entries(input int unsigned a, input int unsigned b);
    logic [KeyW-1:0] k;
    logic [PayW-1:0] p;
    k = heap_key[a];
    p = heap_tag[a];
    heap_key[a] = heap_key[b];
    heap_tag[a] = heap_tag[b];
    heap_key[b] = k;
    heap_tag[b] = p;
  endtask

  task automatic apply_word(input logic is_pop, input logic [KeyW-1:0] k,
                            input logic [PayW-1:0] p, output heap_result_t r);
    int unsigned lim;
    int unsigned pos;
    int unsigned parent;
    int unsigned lft;
    int unsigned best;
    lim = (cap_limit > Cap) ? Cap : cap_limit;
    r = '0;
    r.status = bmhq_pkg::ST_DONE;
    if (!is_pop) begin
      if (held < lim) begin
        pos = held;
        heap_key[pos] = k;
        heap_tag[pos] = p;
        held++;
        while (pos > 0) begin
          parent = (pos - 1) / 2;
          if (heap_key[pos] < heap_key[parent]) begin
            swap_entries(pos, parent);
            pos = parent;
          end else begin
            break;
          end
        end
      end else begin
        r.status = bmhq_pkg::ST_FULL;
      end
    end else if (held == 0) begin
      r.status = bmhq_pkg::ST_EMPTY;
    end else begin
      r.popped_key = heap_key[0];
      r.popped_tag = heap_tag[0];
      held--;
      heap_key[0] = heap_key[held];
      heap_tag[0] = heap_tag[held];
      pos = 0;
      while (2 * pos + 1 < held) begin
        lft = 2 * pos + 1;
        best = lft;
        // left child wins on equal keys
        if (lft + 1 < held && heap_key[lft + 1] < heap_key[lft]) begin
          best = lft + 1;
        end
        if (heap_key[best] < heap_key[pos]) begin
          swap_entries(pos, best);
          pos = best;
        end else begin
          break;
        end
      end
    end
    if (held > 0) begin
      r.top_key = heap_key[0];
      r.top_tag = heap_tag[0];
    end
    r.count = CntW'(held);
    r.empty = (held == 0);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held = 0;
      cap_limit = bmhq_pkg::LimitReset;
      result_q.delete();
      mismatch_o = 0;
      pending_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (result_q.size() == 0) begin
          mismatch_o++;
          if (mismatch_o <= 10) begin
            $display("%0t unexpected result word: st=%0d pk=%h pp=%h", $realtime,
                     status_i, popped_key_i, popped_payload_i);
          end
        end else begin
          exp_r = result_q.pop_front();
          got_r.status = bmhq_pkg::status_e'(status_i);
          got_r.popped_key = popped_key_i;
          got_r.popped_tag = popped_payload_i;
          got_r.top_key = top_key_i;
          got_r.top_tag = top_payload_i;
          got_r.count = entry_count_i;
          got_r.empty = is_empty_i;
          if (got_r.status !== exp_r.status || got_r.popped_key !== exp_r.popped_key ||
              got_r.popped_tag !== exp_r.popped_tag || got_r.top_key !== exp_r.top_key ||
              got_r.top_tag !== exp_r.top_tag || got_r.count !== exp_r.count ||
              got_r.empty !== exp_r.empty) begin
            mismatch_o++;
            if (mismatch_o <= 10) begin
              $display("%0t mismatch exp: st=%0d pk=%h pp=%h tk=%h tp=%h n=%0d e=%0b",
                       $realtime, exp_r.status, exp_r.popped_key, exp_r.popped_tag,
                       exp_r.top_key, exp_r.top_tag, exp_r.count, exp_r.empty);
              $display("%0t          got: st=%0d pk=%h pp=%h tk=%h tp=%h n=%0d e=%0b",
                       $realtime, status_i, popped_key_i, popped_payload_i,
                       top_key_i, top_payload_i, entry_count_i, is_empty_i);
            end
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        apply_word(action_i, key_i, payload_i, exp_r);
        result_q.push_back(exp_r);
      end
      if (cfg_we_i) begin
        cap_limit = cfg_wdata_i;
      end
      pending_o = result_q.size();
    end
  end

endmodule

// File: tb/binary_min_heap_queue_tb.sv
// binary min-heap queue testbench top: clock, reset, stimulus and verdict
// depends on bmhq_pkg, binary_min_heap_queue and binary_min_heap_queue_checker
module binary_min_heap_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic                        action = OP_PUSH;
  logic [15:0]                 key = '0;
  logic [15:0]                 payload = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic [1:0]                  status;
  logic [15:0]                 popped_key;
  logic [15:0]                 popped_payload;
  logic [15:0]                 top_key;
  logic [15:0]                 top_payload;
  logic [6:0]                  entry_count;
  logic                        is_empty;
  logic                        cfg_we = 1'b0;
  logic [bmhq_pkg::LimitW-1:0] cfg_wdata = '0;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_req = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  binary_min_heap_queue u_top (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .action_i         (action),
    .key_i            (key),
    .payload_i        (payload),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .status_o         (status),
    .popped_key_o     (popped_key),
    .popped_payload_o (popped_payload),
    .top_key_o        (top_key),
    .top_payload_o    (top_payload),
    .entry_count_o    (entry_count),
    .is_empty_o       (is_empty),
    .cfg_we_i         (cfg_we),
    .cfg_wdata_i      (cfg_wdata)
  );

  binary_min_heap_queue_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .action_i         (action),
    .key_i            (key),
    .payload_i        (payload),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .status_i         (status),
    .popped_key_i     (popped_key),
    .popped_payload_i (popped_payload),
    .top_key_i        (top_key),
    .top_payload_i    (top_payload),
    .entry_count_i    (entry_count),
    .is_empty_i       (is_empty),
    .cfg_we_i         (cfg_we),
    .cfg_wdata_i      (cfg_wdata),
    .mismatch_o       (mismatches),
    .pending_o        (pending)
  );

  // receiver side, with a long hold-off on request
  initial begin
    int unsigned hold_seen;
    hold_seen = 0;
    forever begin
      @(negedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        out_ready = 1'b0;
        repeat (300) @(negedge clk);
      end else begin
        out_ready = ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    #1_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic logic [15:0] pick_key();
    int unsigned sel;
    sel = $urandom_range(7);
    if (sel < 2) return 16'($urandom_range(7));
    if (sel == 2) return $urandom_range(1) ? 16'hFFFF : 16'h0000;
    return 16'($urandom);
  endfunction

  task automatic send_word(input logic act, input logic [15:0] k, input logic [15:0] p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    action = act;
    key = k;
    payload = p;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic send_batch(input int unsigned n, input int unsigned push_pct);
    repeat (n) begin
      if ($urandom_range(99) < push_pct) begin
        send_word(OP_PUSH, pick_key(), 16'($urandom));
      end else begin
        send_word(OP_POP, 16'($urandom), 16'($urandom));
      end
    end
  endtask

  task automatic write_limit(input logic [bmhq_pkg::LimitW-1:0] val);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (24) @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  initial begin
    int unsigned spins;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // directed: empty pop, extremes, equal keys, limit corner cases
    send_word(OP_POP, 16'hFFFF, 16'hFFFF);
    send_word(OP_PUSH, 16'hFFFF, 16'hFFFF);
    send_word(OP_PUSH, 16'h0000, 16'h0000);
    send_word(OP_PUSH, 16'h8000, 16'h0001);
    send_word(OP_PUSH, 16'h8000, 16'h0002);
    send_word(OP_PUSH, 16'h8000, 16'h0003);
    send_word(OP_PUSH, 16'h0001, 16'hFFFF);
    repeat (7) send_word(OP_POP, 16'h0000, 16'h0000);
    write_limit(7'd0);
    send_word(OP_PUSH, 16'h1234, 16'h5678);
    send_word(OP_POP, 16'h0000, 16'h0000);
    write_limit(7'd1);
    send_word(OP_PUSH, 16'h00AA, 16'h0055);
    send_word(OP_PUSH, 16'h0011, 16'h0022);
    send_word(OP_POP, 16'h0000, 16'h0000);
    write_limit(7'd64);
    repeat (4) send_word(OP_PUSH, pick_key(), 16'($urandom));
    write_limit(7'd2);
    send_word(OP_PUSH, 16'h0002, 16'hA5A5);
    send_word(OP_POP, 16'h0000, 16'h0000);
    send_word(OP_POP, 16'h0000, 16'h0000);

    // random, sender idles less than receiver; limit saturates
    send_idle_pct = 34;
    recv_idle_pct = 71;
    write_limit(7'd127);
    send_batch(100, 85);
    send_batch(50, 20);

    send_idle_pct = 71;
    recv_idle_pct = 34;
    write_limit(bmhq_pkg::LimitW'($urandom_range(12, 1)));
    send_batch(75, 55);
    write_limit(bmhq_pkg::LimitW'($urandom_range(127)));
    send_batch(75, 55);

    // no idling; receiver holds off so the block backs up
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_limit(7'd64);
    hold_req++;
    send_batch(150, 60);

    in_valid = 1'b0;
    spins = 0;
    while (pending != 0 && spins < 20000) begin
      @(negedge clk);
      spins++;
    end
    repeat (40) @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: binary_min_heap_queue.f
hw/rtl/bmhq_pkg.sv
hw/rtl/bmhq_ctrl.sv
hw/rtl/bmhq_datapath.sv
hw/rtl/binary_min_heap_queue.sv
tb/binary_min_heap_queue_checker.sv
tb/binary_min_heap_queue_tb.sv
